// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define PSAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PSAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/psat_pkg.sv =====
// ----------------------------------------------------------------------------
// psat_pkg
// shared types and fixed-point constants of the saturation adjust block
// ----------------------------------------------------------------------------
package psat_pkg;

  localparam int FRAC_BITS  = 16;             // hue fraction bits
  localparam int QUO_BITS   = FRAC_BITS + 1;  // quotient may reach 1.0
  localparam int SAT_BITS   = 9;              // saturation level, q8
  localparam int SCALE_BITS = FRAC_BITS + 8;  // q16 weight times q8 level

  localparam logic [SAT_BITS-1:0] SAT_FULL = 9'd256;
  localparam logic [QUO_BITS-1:0] ONE_Q16  = 17'h10000;

  // channel holding the maximum, ties go to red then green
  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } base_t;

  // part a channel plays when the pixel is rebuilt
  typedef enum logic [1:0] {
    ROLE_CHROMA = 2'd0,
    ROLE_SEC    = 2'd1,
    ROLE_ZERO   = 2'd2
  } role_t;

  typedef struct packed {
    role_t a;
    role_t b;
    role_t c;
  } roles_t;

  function automatic roles_t sext_roles(input logic [2:0] sext);
    roles_t rl;
    unique case (sext)
      3'd0:    rl = '{a: ROLE_CHROMA, b: ROLE_SEC,    c: ROLE_ZERO};
      3'd1:    rl = '{a: ROLE_SEC,    b: ROLE_CHROMA, c: ROLE_ZERO};
      3'd2:    rl = '{a: ROLE_ZERO,   b: ROLE_CHROMA, c: ROLE_SEC};
      3'd3:    rl = '{a: ROLE_ZERO,   b: ROLE_SEC,    c: ROLE_CHROMA};
      3'd4:    rl = '{a: ROLE_SEC,    b: ROLE_ZERO,   c: ROLE_CHROMA};
      default: rl = '{a: ROLE_CHROMA, b: ROLE_ZERO,   c: ROLE_SEC};
    endcase
    return rl;
  endfunction

endpackage

// ===== design/psat_div.sv =====
// ----------------------------------------------------------------------------
// psat_div
// pipelined restoring divider, floor(num * 2^16 / den) for num <= den,
// one quotient bit per register stage, tag travels alongside
// ----------------------------------------------------------------------------
module psat_div #(
  parameter int CB = 8,
  parameter int TW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [CB-1:0]                 num,
  input  logic [CB-1:0]                 den,
  input  logic [TW-1:0]                 in_tag,
  output logic                          out_valid,
  output logic [psat_pkg::QUO_BITS-1:0] quo,
  output logic [TW-1:0]                 out_tag
);
  import psat_pkg::*;

  logic                vld     [QUO_BITS];
  logic [CB-1:0]       rem     [QUO_BITS];
  logic [CB-1:0]       den_r   [QUO_BITS];
  logic [QUO_BITS-1:0] quo_r   [QUO_BITS];
  logic [TW-1:0]       tag_r   [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [CB:0]         trial;
    logic [CB-1:0]       d_in;
    logic [QUO_BITS-1:0] q_prev;
    logic [TW-1:0]       t_in;
    logic                v_in;
    logic                ge;
    logic [CB-1:0]       rem_next;
    logic [QUO_BITS-1:0] quo_next;

    if (k == 0) begin : g_first
      // top bit: num itself against den
      assign trial  = {1'b0, num};
      assign d_in   = den;
      assign q_prev = '0;
      assign t_in   = in_tag;
      assign v_in   = in_valid;
    end else begin : g_next
      assign trial  = {rem[k-1], 1'b0};
      assign d_in   = den_r[k-1];
      assign q_prev = quo_r[k-1];
      assign t_in   = tag_r[k-1];
      assign v_in   = vld[k-1];
    end

    assign ge       = trial >= {1'b0, d_in};
    // remainder stays below den, so it fits in CB bits
    assign rem_next = ge ? CB'(trial - {1'b0, d_in}) : trial[CB-1:0];
    assign quo_next = ge ? (q_prev | (QUO_BITS'(1) << (QUO_BITS - 1 - k))) : q_prev;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k]   <= rem_next;
        den_r[k] <= d_in;
        quo_r[k] <= quo_next;
        tag_r[k] <= t_in;
      end
    end
  end

  assign out_valid = vld[QUO_BITS-1];
  assign quo       = quo_r[QUO_BITS-1];
  assign out_tag   = tag_r[QUO_BITS-1];

endmodule

// ===== design/pixel_saturation_set.sv =====
// ----------------------------------------------------------------------------
// pixel_saturation_set
// replaces the hsv saturation of each rgb pixel with a programmed level
// and rebuilds the pixel at the same value
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  input    | in_valid / in_ready   | chan_a, chan_b, chan_c
//  output   | out_valid / out_ready | out_a, out_b, out_c
//  config   | sat_level_we          | sat_level (q8, 9 bits)
//
// one item per clock sustained while the skid entry is empty; the path from
// accept to out_valid is the 17-stage hue divider (one quotient bit per stage)
// plus one front stage, two multiply stages and the output register.
// rst is synchronous; it empties the pipeline and clears sat_level to 0.
// an output register plus one skid entry sit behind the pipeline; the
// pipeline freezes only while the skid entry is full, so in_ready is a
// register and does not depend on out_ready in the same cycle.
// ----------------------------------------------------------------------------
module pixel_saturation_set #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sat_level_we,
  input  logic [psat_pkg::SAT_BITS-1:0] sat_level,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CHANNEL_BITS-1:0]       chan_a,
  input  logic [CHANNEL_BITS-1:0]       chan_b,
  input  logic [CHANNEL_BITS-1:0]       chan_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHANNEL_BITS-1:0]       out_a,
  output logic [CHANNEL_BITS-1:0]       out_b,
  output logic [CHANNEL_BITS-1:0]       out_c
);
  import psat_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int MS_W  = CB + SAT_BITS;        // mx times level
  localparam int PR_W  = MS_W + QUO_BITS;      // full product width
  localparam int CUT_W = CB + SCALE_BITS;      // cut never exceeds mx * 2^24

  // what travels beside the divider
  typedef struct packed {
    logic [CB-1:0] mx;
    base_t         base;
    logic          negf;
  } tag_t;

  // saturation level, clamped to full on write
  logic [SAT_BITS-1:0] sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= '0;
    end else if (sat_level_we) begin
      sat <= (sat_level > SAT_FULL) ? SAT_FULL : sat_level;
    end
  end

  // pipeline advance: stop only when the skid entry holds an item
  logic skid_v;
  logic ce;

  assign ce       = !skid_v;
  assign in_ready = ce;

  // ---- stage 1: max, min, hue numerator and denominator -------------------
  logic [CB-1:0] mx_c, mn_c, pos_c, neg_c, d_c;
  base_t         base_c;
  logic          negf_c;

  always_comb begin
    mx_c = chan_a;
    if (chan_b > mx_c) mx_c = chan_b;
    if (chan_c > mx_c) mx_c = chan_c;
    mn_c = chan_a;
    if (chan_b < mn_c) mn_c = chan_b;
    if (chan_c < mn_c) mn_c = chan_c;
    // ties resolve red first, then green
    priority if (mx_c == chan_a) begin
      base_c = BASE_RED;
      pos_c  = chan_b;
      neg_c  = chan_c;
    end else if (mx_c == chan_b) begin
      base_c = BASE_GREEN;
      pos_c  = chan_c;
      neg_c  = chan_a;
    end else begin
      base_c = BASE_BLUE;
      pos_c  = chan_a;
      neg_c  = chan_b;
    end
    negf_c = neg_c > pos_c;
    d_c    = mx_c - mn_c;
  end

  logic          s1_v;
  logic [CB-1:0] s1_num, s1_den;
  tag_t          s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (ce) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_num <= negf_c ? neg_c - pos_c : pos_c - neg_c;
      // grey pixel: numerator is zero, a denominator of one gives hue 0
      s1_den <= (d_c == '0) ? CB'(1) : d_c;
      s1_tag <= '{mx: mx_c, base: base_c, negf: negf_c};
    end
  end

  // ---- divider stages ----------------------------------------------------
  logic                dv_v;
  logic [QUO_BITS-1:0] dv_quo;
  logic [$bits(tag_t)-1:0] dv_tag_bits;
  tag_t                dv_tag;

  psat_div #(
    .CB (CB),
    .TW ($bits(tag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s1_v),
    .num       (s1_num),
    .den       (s1_den),
    .in_tag    (s1_tag),
    .out_valid (dv_v),
    .quo       (dv_quo),
    .out_tag   (dv_tag_bits)
  );

  assign dv_tag = tag_t'(dv_tag_bits);

  // ---- post 1: hue position, sextant, weight; mx times level -------------
  logic [2:0]            base3_c, top3_c;
  logic [QUO_BITS+1:0]   p_c;          // hue in q16, below 6.0
  logic [2:0]            sext_c;
  logic [FRAC_BITS-1:0]  f_c;

  always_comb begin
    base3_c = {dv_tag.base, 1'b0};
    top3_c  = (dv_tag.base == BASE_RED) ? 3'd6 : base3_c;
    if (dv_tag.negf) begin
      p_c = {top3_c, {FRAC_BITS{1'b0}}} - {2'b00, dv_quo};
    end else begin
      p_c = {base3_c, {FRAC_BITS{1'b0}}} + {2'b00, dv_quo};
    end
    sext_c = p_c[FRAC_BITS+2:FRAC_BITS];
    f_c    = p_c[FRAC_BITS-1:0];
  end

  logic                p1_v;
  logic [CB-1:0]       p1_mx;
  logic [MS_W-1:0]     p1_ms;
  logic [QUO_BITS-1:0] p1_om;          // one minus secondary weight
  roles_t              p1_roles;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (ce) begin
      p1_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_mx    <= dv_tag.mx;
      p1_ms    <= MS_W'(dv_tag.mx) * MS_W'(sat);
      // odd sextant: weight is 1 - f, so 1 - weight is f
      p1_om    <= sext_c[0] ? {1'b0, f_c} : ONE_Q16 - {1'b0, f_c};
      p1_roles <= sext_roles(sext_c);
    end
  end

  // ---- post 2: secondary channel cut -------------------------------------
  logic [PR_W-1:0] prod_c;

  assign prod_c = PR_W'(p1_ms) * PR_W'(p1_om);

  logic             p2_v;
  logic [CB-1:0]    p2_mx;
  logic [MS_W-1:0]  p2_ms;
  logic [CUT_W-1:0] p2_cut;
  roles_t           p2_roles;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (ce) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p2_mx    <= p1_mx;
      p2_ms    <= p1_ms;
      p2_cut   <= prod_c[CUT_W-1:0];
      p2_roles <= p1_roles;
    end
  end

  // ---- post 3: rebuild each channel, truncated toward zero ---------------
  function automatic logic [CB-1:0] chan_out(
    input role_t            rl,
    input logic [CB-1:0]    mx,
    input logic [MS_W-1:0]  ms,
    input logic [CUT_W-1:0] cut_sec
  );
    logic [CUT_W-1:0] cut;
    logic [CUT_W-1:0] diff;
    unique case (rl)
      ROLE_CHROMA: cut = '0;
      ROLE_SEC:    cut = cut_sec;
      ROLE_ZERO:   cut = CUT_W'({ms, {FRAC_BITS{1'b0}}});
      default:     cut = '0;
    endcase
    diff = {mx, {SCALE_BITS{1'b0}}} - cut;
    return diff[CUT_W-1:SCALE_BITS];
  endfunction

  logic [CB-1:0] res_a, res_b, res_c;

  assign res_a = chan_out(p2_roles.a, p2_mx, p2_ms, p2_cut);
  assign res_b = chan_out(p2_roles.b, p2_mx, p2_ms, p2_cut);
  assign res_c = chan_out(p2_roles.c, p2_mx, p2_ms, p2_cut);

  // ---- output register and skid entry ------------------------------------
  logic [CB-1:0] skid_a, skid_b, skid_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      // pipeline frozen, drain the skid entry
      if (out_ready) begin
        skid_v <= 1'b0;
      end
    end else if (p2_v) begin
      if (out_valid && !out_ready) begin
        skid_v <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_ready) begin
        out_a <= skid_a;
        out_b <= skid_b;
        out_c <= skid_c;
      end
    end else if (p2_v) begin
      if (out_valid && !out_ready) begin
        skid_a <= res_a;
        skid_b <= res_b;
        skid_c <= res_c;
      end else begin
        out_a <= res_a;
        out_b <= res_b;
        out_c <= res_c;
      end
    end
  end

endmodule

// ===== design/psat_chk.sv =====
// ----------------------------------------------------------------------------
// psat_chk
// port-level checks of the saturation adjust block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psat_chk #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CHANNEL_BITS-1:0] out_a,
  input logic [CHANNEL_BITS-1:0] out_b,
  input logic [CHANNEL_BITS-1:0] out_c
);

  // the three result channels seen as one word
  logic [3*CHANNEL_BITS-1:0] res_bits;

  assign res_bits = {out_a, out_b, out_c};

  // a stalled result stays offered
  `PSAT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a stalled result keeps its value
  `PSAT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(res_bits), "result changed")

  // input side only backs up behind a waiting result
  `PSAT_ASSERT(a_stall_cause, !in_ready |-> out_valid, "input stalled with no result waiting")

  // reset leaves the pipeline empty and open
  `PSAT_ASSERT_RST(a_reset_open, rst |=> in_ready && !out_valid, "not empty after reset")

endmodule

bind pixel_saturation_set psat_chk #(.CHANNEL_BITS(CHANNEL_BITS)) u_psat_chk (.*);

// ===== sim/pixel_saturation_set_test.sv =====
// ----------------------------------------------------------------------------
// pixel_saturation_set_test
// drives rgb pixels through the saturation adjust block under several
// programmed levels and random stalls on both sides, predicts every result
// pixel in fixed point and compares it channel by channel in arrival order
// ----------------------------------------------------------------------------
module pixel_saturation_set_test;

  localparam int CHANNEL_BITS = 8;
  localparam int QUIET_LIMIT  = 3000;   // cycles with no item moving on either side
  localparam int PHASE_ITEMS  = 170;
  localparam int NUM_PHASES   = 9;
  localparam int DRAIN_CYCLES = 40;     // extra cycles after the last expected pixel

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] a;   // red
    logic [CHANNEL_BITS-1:0] b;   // green
    logic [CHANNEL_BITS-1:0] c;   // blue
  } pixel_t;

  // expected pixels in arrival order, plus the programmed level they use
  class pixel_board;
    pixel_t                          waiting[$];
    logic [psat_pkg::SAT_BITS-1:0]   level;
    int                              errors;

    function new();
      level  = '0;
      errors = 0;
    endfunction

    // one rebuilt channel: value minus value times level times (1 - weight)
    function longint unsigned channel_level(longint unsigned mx, longint unsigned s,
                                            longint unsigned w);
      longint unsigned top, cut;
      top = mx << 24;
      cut = mx * s * (64'd65536 - w);
      return ((top - cut) >> 24) & ((64'd1 << CHANNEL_BITS) - 1);
    endfunction

    // hue by sextant in q16, saturation replaced, pixel rebuilt at max channel
    function pixel_t resaturate(pixel_t px);
      longint unsigned r, g, b, mx, mn, d, pos, neg, base, p, f, fx, s;
      longint unsigned wr, wg, wb;
      pixel_t res;
      r  = 64'(px.a);
      g  = 64'(px.b);
      b  = 64'(px.c);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      p = 0;
      if (d != 0) begin
        // ties resolve toward red, then green
        if (mx == r) begin
          pos = g; neg = b; base = 0;
        end else if (mx == g) begin
          pos = b; neg = r; base = 2;
        end else begin
          pos = r; neg = g; base = 4;
        end
        if (pos >= neg) p = base * 64'd65536 + ((pos - neg) << 16) / d;
        else p = ((base == 0) ? 64'd6 : base) * 64'd65536 - ((neg - pos) << 16) / d;
      end
      f  = p & 64'hFFFF;
      fx = ((p >> 16) & 1) ? (64'd65536 - f) : f;
      case (p >> 16)
        0: begin wr = 65536; wg = fx;    wb = 0;     end
        1: begin wr = fx;    wg = 65536; wb = 0;     end
        2: begin wr = 0;     wg = 65536; wb = fx;    end
        3: begin wr = 0;     wg = fx;    wb = 65536; end
        4: begin wr = fx;    wg = 0;     wb = 65536; end
        default: begin wr = 65536; wg = 0; wb = fx; end
      endcase
      s = 64'((level > psat_pkg::SAT_FULL) ? psat_pkg::SAT_FULL : level);
      res.a = CHANNEL_BITS'(channel_level(mx, s, wr));
      res.b = CHANNEL_BITS'(channel_level(mx, s, wg));
      res.c = CHANNEL_BITS'(channel_level(mx, s, wb));
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      waiting.push_back(resaturate(px));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (waiting.size() == 0) begin
        errors++;
        $display("%0t unexpected pixel expected none actual %0d %0d %0d",
                 $time, got.a, got.b, got.c);
        return;
      end
      exp_px = waiting.pop_front();
      if (got.a !== exp_px.a || got.b !== exp_px.b || got.c !== exp_px.c) begin
        errors++;
        $display("%0t pixel mismatch expected %0d %0d %0d actual %0d %0d %0d",
                 $time, exp_px.a, exp_px.b, exp_px.c, got.a, got.b, got.c);
      end
    endfunction

    function int pending();
      return waiting.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          sat_level_we;
  logic [psat_pkg::SAT_BITS-1:0] sat_level;
  logic                          in_valid;
  logic                          in_ready;
  logic [CHANNEL_BITS-1:0]       chan_a, chan_b, chan_c;
  logic                          out_valid;
  logic                          out_ready;
  logic [CHANNEL_BITS-1:0]       out_a, out_b, out_c;

  pixel_board sb = new();

  // idle odds in percent, and a long receiver hold counted down below
  int send_idle;
  int recv_idle;
  int hold_left;

  pixel_saturation_set #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .sat_level_we (sat_level_we),
    .sat_level    (sat_level),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .chan_a       (chan_a),
    .chan_b       (chan_b),
    .chan_c       (chan_c),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_a        (out_a),
    .out_b        (out_b),
    .out_c        (out_c)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one item at a falling edge, hold it until the rising edge that takes it
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    chan_a   <= px.a;
    chan_b   <= px.b;
    chan_c   <= px.c;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  // sender stops offering until every expected pixel has come out
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // program the level only with the pipeline empty
  task automatic set_level(input logic [psat_pkg::SAT_BITS-1:0] v);
    drain_pixels();
    sat_level_we <= 1'b1;
    sat_level    <= v;
    sb.level      = v;
    @(negedge clk);
    sat_level_we <= 1'b0;
    // junk on the data lines while the enable is low must not land
    sat_level    <= (psat_pkg::SAT_BITS)'($urandom_range(0, 511));
  endtask

  // mostly plain random, with grey pixels, tied maxima and extreme channels mixed in
  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [CHANNEL_BITS-1:0] v, w;
    px = {CHANNEL_BITS'($urandom), CHANNEL_BITS'($urandom), CHANNEL_BITS'($urandom)};
    v  = CHANNEL_BITS'($urandom);
    w  = CHANNEL_BITS'($urandom_range(0, v));
    case ($urandom_range(0, 9))
      0: px = '{v, v, v};
      1: begin
        case ($urandom_range(0, 2))
          0: px = '{v, v, w};
          1: px = '{w, v, v};
          default: px = '{v, w, v};
        endcase
      end
      2: begin
        px.a = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 1) != 0) px.b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 1) != 0) px.c = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  // receiver: random ready at the falling edge, or a forced long hold
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // every pixel taken at the output goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel('{out_a, out_b, out_c});
  end

  // watchdog: too long with nothing moving on either side ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    // a few pixels under the reset level, where every channel keeps the max
    pixel_t reset_px[3] = '{'{8'd200, 8'd50, 8'd10}, '{8'd7, 8'd7, 8'd7},
                            '{8'd0, 8'd255, 8'd1}};
    // grey, one per sextant, tied maxima, single channels and tiny values
    pixel_t edge_px[18] = '{
      '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
      '{8'd255, 8'd128, 8'd0},   '{8'd128, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd128},
      '{8'd0,   8'd128, 8'd255}, '{8'd128, 8'd0,   8'd255}, '{8'd255, 8'd0,   8'd128},
      '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd0,   8'd255},
      '{8'd1,   8'd0,   8'd0},   '{8'd255, 8'd254, 8'd253}, '{8'd1,   8'd2,   8'd3}};
    // extremes, above-full values, and one random level
    logic [psat_pkg::SAT_BITS-1:0] phase_level[NUM_PHASES] =
      '{9'd128, 9'd511, 9'd1, 9'd256, 9'd0, 9'd0, 9'd255, 9'd257, 9'd64};
    int ph;
    int i;

    rst          = 1'b1;
    sat_level_we = 1'b0;
    sat_level    = '0;
    in_valid     = 1'b0;
    chan_a       = '0;
    chan_b       = '0;
    chan_c       = '0;
    send_idle    = 0;
    recv_idle    = 0;
    hold_left    = 0;
    phase_level[5] = (psat_pkg::SAT_BITS)'($urandom_range(0, 511));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, no stalls
    foreach (reset_px[k]) send_pixel(reset_px[k]);
    set_level(psat_pkg::SAT_FULL);
    foreach (edge_px[k]) send_pixel(edge_px[k]);

    // random phases: slow receiver, then slow sender, then no idling at all
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_level(phase_level[ph]);
      if (ph < 3) begin
        send_idle = 13; recv_idle = 81;
      end else if (ph < 6) begin
        send_idle = 81; recv_idle = 13;
      end else begin
        send_idle = 0;  recv_idle = 0;
      end
      // long output hold while the sender keeps pushing, so the input backs up
      if (ph == 6) hold_left = 100;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) drain_pixels();
        send_pixel(random_pixel());
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== pixel_saturation_set.f =====
+incdir+design
design/psat_pkg.sv
design/psat_div.sv
design/pixel_saturation_set.sv
design/psat_chk.sv
sim/pixel_saturation_set_test.sv
